// ----- rtl/bftd_pkg.sv -----
package bftd_pkg;

  localparam int TABLE_DEPTH      = 1024;
  localparam int TRACK_LIMIT_BASE = 1000;
  localparam int TRACK_LIMIT      = (TABLE_DEPTH < TRACK_LIMIT_BASE) ? TABLE_DEPTH
                                                                     : TRACK_LIMIT_BASE;
  localparam int MEM_AW           = $clog2(TRACK_LIMIT);
  localparam int FILL_W           = $clog2(TRACK_LIMIT + 1);

  localparam int QUEUE_DEPTH      = 2;
  localparam int QUEUE_AW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

  localparam int COORD_W          = 16;
  localparam int CONF_W           = 16;
  localparam int ID_W             = 32;
  localparam int PIX_W            = 11;
  localparam int CNT_W            = 16;
  localparam int GEO_W            = 18;

  localparam int NUM_REGS         = 7;
  localparam int CFG_DW           = 32;
  localparam int CFG_AW           = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W        = CFG_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_BORDER   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_IMG_W    = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_IMG_H    = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_MIN_W    = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_MIN_H    = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_SKIP     = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_MIN_CONF = REG_IDX_W'(6);

  localparam logic [PIX_W-1:0]  RST_BORDER   = PIX_W'(20);
  localparam logic [PIX_W-1:0]  RST_IMG_W    = PIX_W'(1920);
  localparam logic [PIX_W-1:0]  RST_IMG_H    = PIX_W'(1080);
  localparam logic [PIX_W-1:0]  RST_MIN_W    = PIX_W'(100);
  localparam logic [PIX_W-1:0]  RST_MIN_H    = PIX_W'(100);
  localparam logic [CNT_W-1:0]  RST_SKIP     = CNT_W'(5);
  localparam logic [CONF_W-1:0] RST_MIN_CONF = CONF_W'(26214);

  typedef enum logic [1:0] {
    OUT_NEW    = 2'd0,
    OUT_PERIOD = 2'd1,
    OUT_SKIP   = 2'd2,
    OUT_REJECT = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HIT,
    ST_MISS
  } back_state_t;

  typedef struct packed {
    logic [PIX_W-1:0]  border_px;
    logic [PIX_W-1:0]  image_width;
    logic [PIX_W-1:0]  image_height;
    logic [PIX_W-1:0]  min_box_width;
    logic [PIX_W-1:0]  min_box_height;
    logic [CNT_W-1:0]  skip_period;
    logic [CONF_W-1:0] min_confidence;
  } cfg_t;

  typedef struct packed {
    logic            ok;
    logic [ID_W-1:0] id;
  } q_entry_t;

endpackage

// ----- rtl/bftd_box_if.sv -----
interface bftd_box_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bftd_pkg::COORD_W-1:0]  left_x;
  logic signed [bftd_pkg::COORD_W-1:0]  top_y;
  logic signed [bftd_pkg::COORD_W-1:0]  right_x;
  logic signed [bftd_pkg::COORD_W-1:0]  bottom_y;
  logic        [bftd_pkg::CONF_W-1:0]   confidence;
  logic        [bftd_pkg::ID_W-1:0]     track_id;

  modport source (
    output valid, left_x, top_y, right_x, bottom_y, confidence, track_id,
    input  ready
  );
  modport sink (
    input  valid, left_x, top_y, right_x, bottom_y, confidence, track_id,
    output ready
  );
endinterface

// ----- rtl/bftd_res_if.sv -----
interface bftd_res_if;
  logic                          valid;
  logic                          ready;
  logic                          passed;
  logic [1:0]                    outcome;
  logic [bftd_pkg::ID_W-1:0]     echo_id;

  modport source (
    output valid, passed, outcome, echo_id,
    input  ready
  );
  modport sink (
    input  valid, passed, outcome, echo_id,
    output ready
  );
endinterface

// ----- rtl/bftd_front.sv -----
module bftd_front (
  bftd_box_if.sink               box,
  input  bftd_pkg::cfg_t         cfg,
  input  logic                   q_full,
  output logic                   push,
  output bftd_pkg::q_entry_t     push_data
);

  logic signed [bftd_pkg::GEO_W-1:0] lx, ty, rx, by;
  logic signed [bftd_pkg::GEO_W-1:0] b_lim, w_lim, h_lim, min_w, min_h;
  logic signed [bftd_pkg::GEO_W-1:0] box_w, box_h;
  logic                              geo_ok;

  // All limits in Q12.4, 18-bit signed covers every combination.
  always_comb begin
    lx    = bftd_pkg::GEO_W'(box.left_x);
    ty    = bftd_pkg::GEO_W'(box.top_y);
    rx    = bftd_pkg::GEO_W'(box.right_x);
    by    = bftd_pkg::GEO_W'(box.bottom_y);
    b_lim = $signed({3'b000, cfg.border_px, 4'b0000});
    w_lim = ($signed({7'b0, cfg.image_width}) - $signed({7'b0, cfg.border_px})) <<< 4;
    h_lim = ($signed({7'b0, cfg.image_height}) - $signed({7'b0, cfg.border_px})) <<< 4;
    min_w = $signed({3'b000, cfg.min_box_width, 4'b0000});
    min_h = $signed({3'b000, cfg.min_box_height, 4'b0000});
    box_w = rx - lx;
    box_h = by - ty;
    geo_ok = (lx > b_lim) && (ty > b_lim) && (rx < w_lim) && (by < h_lim) &&
             (box_h > min_h) && (box_w > min_w) &&
             (box.confidence >= cfg.min_confidence);
  end

  assign box.ready    = !q_full;
  assign push         = box.valid && !q_full;
  assign push_data.ok = geo_ok;
  assign push_data.id = box.track_id;

endmodule

// ----- rtl/bftd_queue.sv -----
module bftd_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  bftd_pkg::q_entry_t     push_data,
  output logic                   full,
  input  logic                   pop,
  output bftd_pkg::q_entry_t     pop_data,
  output logic                   empty
);

  bftd_pkg::q_entry_t                 mem_r [bftd_pkg::QUEUE_DEPTH];
  logic [bftd_pkg::QUEUE_AW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [bftd_pkg::QUEUE_AW-1:0]      wr_ptr_nxt, rd_ptr_nxt;
  logic [bftd_pkg::QCNT_W-1:0]        cnt_r;

  assign full     = (cnt_r == bftd_pkg::QCNT_W'(bftd_pkg::QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == bftd_pkg::QUEUE_AW'(bftd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == bftd_pkg::QUEUE_AW'(bftd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_nxt;
      if (pop)  rd_ptr_r <= rd_ptr_nxt;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ----- rtl/bftd_back.sv -----
module bftd_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [bftd_pkg::CNT_W-1:0]       skip_period,
  input  logic                             q_empty,
  input  bftd_pkg::q_entry_t               q_data,
  output logic                             pop,
  bftd_res_if.source                       res
);

  logic [bftd_pkg::ID_W-1:0]   id_mem  [bftd_pkg::TRACK_LIMIT];
  logic [bftd_pkg::CNT_W-1:0]  cnt_mem [bftd_pkg::TRACK_LIMIT];

  bftd_pkg::back_state_t            state_r, state_nxt;
  logic [bftd_pkg::FILL_W-1:0]      fill_r, idx_r;
  logic [bftd_pkg::MEM_AW-1:0]      oldest_r, oldest_nxt;
  logic [bftd_pkg::MEM_AW-1:0]      cmp_idx_r, hit_idx_r;
  logic                             cmp_vld_r, cmp_last_r;
  logic [bftd_pkg::ID_W-1:0]        cur_id_r, rd_id_r;
  logic [bftd_pkg::CNT_W-1:0]       rd_cnt_r, hit_cnt_r;

  logic                             out_vld_r, out_passed_r;
  bftd_pkg::outcome_t               out_outcome_r;
  logic [bftd_pkg::ID_W-1:0]        out_id_r;

  logic                             out_free, issue, hit, term, tbl_full;
  logic [bftd_pkg::CNT_W-1:0]       cnt_inc;

  logic                             mem_we, ins_we, out_load;
  logic [bftd_pkg::MEM_AW-1:0]      wr_addr;
  logic [bftd_pkg::CNT_W-1:0]       wr_cnt;
  logic                             out_passed_nxt;
  bftd_pkg::outcome_t               out_outcome_nxt;
  logic [bftd_pkg::ID_W-1:0]        out_id_nxt;

  assign out_free = !out_vld_r || res.ready;
  assign issue    = (idx_r < fill_r);
  assign hit      = (rd_id_r == cur_id_r);
  assign term     = cmp_vld_r && (hit || cmp_last_r);
  assign tbl_full = (fill_r == bftd_pkg::FILL_W'(bftd_pkg::TRACK_LIMIT));
  assign cnt_inc  = (hit_cnt_r == '1) ? hit_cnt_r : hit_cnt_r + 1'b1;
  assign oldest_nxt = (oldest_r == bftd_pkg::MEM_AW'(bftd_pkg::TRACK_LIMIT - 1)) ? '0
                                                                                : oldest_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bftd_pkg::ST_IDLE: begin
        if (!q_empty && out_free && q_data.ok) begin
          state_nxt = (fill_r == '0) ? bftd_pkg::ST_MISS : bftd_pkg::ST_SEARCH;
        end
      end
      bftd_pkg::ST_SEARCH: begin
        if (cmp_vld_r && hit)             state_nxt = bftd_pkg::ST_HIT;
        else if (cmp_vld_r && cmp_last_r) state_nxt = bftd_pkg::ST_MISS;
      end
      bftd_pkg::ST_HIT:  state_nxt = bftd_pkg::ST_IDLE;
      bftd_pkg::ST_MISS: state_nxt = bftd_pkg::ST_IDLE;
      default:           state_nxt = bftd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop             = 1'b0;
    mem_we          = 1'b0;
    ins_we          = 1'b0;
    out_load        = 1'b0;
    wr_addr         = hit_idx_r;
    wr_cnt          = '0;
    out_passed_nxt  = 1'b0;
    out_outcome_nxt = bftd_pkg::OUT_REJECT;
    out_id_nxt      = cur_id_r;
    case (state_r)
      bftd_pkg::ST_IDLE: begin
        pop = !q_empty && out_free;
        if (pop && !q_data.ok) begin
          out_load   = 1'b1;
          out_id_nxt = q_data.id;
        end
      end
      bftd_pkg::ST_HIT: begin
        mem_we   = 1'b1;
        out_load = 1'b1;
        if (cnt_inc >= skip_period) begin
          out_passed_nxt  = 1'b1;
          out_outcome_nxt = bftd_pkg::OUT_PERIOD;
        end else begin
          wr_cnt          = cnt_inc;
          out_outcome_nxt = bftd_pkg::OUT_SKIP;
        end
      end
      bftd_pkg::ST_MISS: begin
        mem_we          = 1'b1;
        ins_we          = 1'b1;
        out_load        = 1'b1;
        // oldest stays zero until the table fills
        wr_addr         = tbl_full ? oldest_r : fill_r[bftd_pkg::MEM_AW-1:0];
        out_passed_nxt  = 1'b1;
        out_outcome_nxt = bftd_pkg::OUT_NEW;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bftd_pkg::ST_IDLE;
      fill_r    <= '0;
      oldest_r  <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= (state_r == bftd_pkg::ST_SEARCH) && issue && !term;
      if (ins_we && tbl_full)  oldest_r <= oldest_nxt;
      if (ins_we && !tbl_full) fill_r   <= fill_r + 1'b1;
      if (out_load)                out_vld_r <= 1'b1;
      else if (out_vld_r && res.ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_id_r <= q_data.id;
      idx_r    <= '0;
    end else if ((state_r == bftd_pkg::ST_SEARCH) && issue) begin
      idx_r    <= idx_r + 1'b1;
    end
    cmp_idx_r  <= idx_r[bftd_pkg::MEM_AW-1:0];
    cmp_last_r <= ((idx_r + 1'b1) == fill_r);
    if (cmp_vld_r && hit) begin
      hit_idx_r <= cmp_idx_r;
      hit_cnt_r <= rd_cnt_r;
    end
    if (out_load) begin
      out_passed_r  <= out_passed_nxt;
      out_outcome_r <= out_outcome_nxt;
      out_id_r      <= out_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      id_mem[wr_addr]  <= cur_id_r;
      cnt_mem[wr_addr] <= wr_cnt;
    end
    rd_id_r  <= id_mem[idx_r[bftd_pkg::MEM_AW-1:0]];
    rd_cnt_r <= cnt_mem[idx_r[bftd_pkg::MEM_AW-1:0]];
  end

  assign res.valid   = out_vld_r;
  assign res.passed  = out_passed_r;
  assign res.outcome = out_outcome_r;
  assign res.echo_id = out_id_r;

endmodule

// ----- rtl/box_filter_track_decimator.sv -----
// Detection box filter with per-track decimation.
// in_box: one box per transfer (Q12.4 corners, Q1.15 confidence, track id).
// out_res: one result per input box, in order: passed, outcome, echo_id.
// Config: APB-style write/read port, registers at byte address 4*index,
//   to be written only while the block is idle; the block does not enforce it.
// A front stage checks geometry and score as the box is taken and pushes
// the verdict into a 2-entry queue, so in_box keeps accepting while the
// back end works, until the queue is full. The back end searches the track
// table (up to 1000 ids) one entry per cycle through a registered memory read.
// Path: a rejected box goes through the queue and the output register to
//   out_res with no search; a box that passes the checks is searched for up
//   to the table slot it matches, or over all filled slots for an unseen id.
// Throughput: rejected boxes one per cycle while out_res takes them; others one per search time.
// Reset: clears the queue, the output valid flag, the fill level and the
//   eviction pointer, and loads register defaults; no clearing pass.
// A stalled out_res holds its result; the queue then fills and in_box.ready
//   drops until the result is taken.
module box_filter_track_decimator (
  input  logic                            clk,
  input  logic                            rst_n,
  bftd_box_if.sink                        in_box,
  bftd_res_if.source                      out_res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bftd_pkg::CFG_AW-1:0]     paddr,
  input  logic [bftd_pkg::CFG_DW-1:0]     pwdata,
  output logic [bftd_pkg::CFG_DW-1:0]     prdata,
  output logic                            pready
);

  bftd_pkg::cfg_t                    cfg_r;
  logic [bftd_pkg::REG_IDX_W-1:0]    reg_idx;
  logic                              cfg_wr;
  logic                              q_full, q_empty, push, pop;
  bftd_pkg::q_entry_t                push_data, pop_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[bftd_pkg::CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.border_px      <= bftd_pkg::RST_BORDER;
      cfg_r.image_width    <= bftd_pkg::RST_IMG_W;
      cfg_r.image_height   <= bftd_pkg::RST_IMG_H;
      cfg_r.min_box_width  <= bftd_pkg::RST_MIN_W;
      cfg_r.min_box_height <= bftd_pkg::RST_MIN_H;
      cfg_r.skip_period    <= bftd_pkg::RST_SKIP;
      cfg_r.min_confidence <= bftd_pkg::RST_MIN_CONF;
    end else if (cfg_wr) begin
      case (reg_idx)
        bftd_pkg::REG_BORDER:   cfg_r.border_px      <= pwdata[bftd_pkg::PIX_W-1:0];
        bftd_pkg::REG_IMG_W:    cfg_r.image_width    <= pwdata[bftd_pkg::PIX_W-1:0];
        bftd_pkg::REG_IMG_H:    cfg_r.image_height   <= pwdata[bftd_pkg::PIX_W-1:0];
        bftd_pkg::REG_MIN_W:    cfg_r.min_box_width  <= pwdata[bftd_pkg::PIX_W-1:0];
        bftd_pkg::REG_MIN_H:    cfg_r.min_box_height <= pwdata[bftd_pkg::PIX_W-1:0];
        bftd_pkg::REG_SKIP:     cfg_r.skip_period    <= pwdata[bftd_pkg::CNT_W-1:0];
        bftd_pkg::REG_MIN_CONF: cfg_r.min_confidence <= pwdata[bftd_pkg::CONF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      bftd_pkg::REG_BORDER:   prdata = bftd_pkg::CFG_DW'(cfg_r.border_px);
      bftd_pkg::REG_IMG_W:    prdata = bftd_pkg::CFG_DW'(cfg_r.image_width);
      bftd_pkg::REG_IMG_H:    prdata = bftd_pkg::CFG_DW'(cfg_r.image_height);
      bftd_pkg::REG_MIN_W:    prdata = bftd_pkg::CFG_DW'(cfg_r.min_box_width);
      bftd_pkg::REG_MIN_H:    prdata = bftd_pkg::CFG_DW'(cfg_r.min_box_height);
      bftd_pkg::REG_SKIP:     prdata = bftd_pkg::CFG_DW'(cfg_r.skip_period);
      bftd_pkg::REG_MIN_CONF: prdata = bftd_pkg::CFG_DW'(cfg_r.min_confidence);
      default:                prdata = '0;
    endcase
  end

  bftd_front u_front (
    .box       (in_box),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  bftd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  bftd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .skip_period (cfg_r.skip_period),
    .q_empty     (q_empty),
    .q_data      (pop_data),
    .pop         (pop),
    .res         (out_res)
  );

endmodule

// ----- rtl/bftd_checker.sv -----
module bftd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_passed,
  input logic [1:0]                    out_outcome,
  input logic [bftd_pkg::ID_W-1:0]     out_echo_id
);

  logic [2:0] pend_r;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {2'b00, in_xfer} - {2'b00, out_xfer};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_echo_id) &&
      $stable(out_outcome) && $stable(out_passed))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_pass_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_passed == ((out_outcome == bftd_pkg::OUT_NEW) ||
                                  (out_outcome == bftd_pkg::OUT_PERIOD))))
    else $error("passed flag disagrees with outcome");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> (pend_r != 3'd0))
    else $error("result without a pending box");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd4)
    else $error("too many boxes in flight");

endmodule

bind box_filter_track_decimator bftd_checker u_bftd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_box.valid),
  .in_ready    (in_box.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .out_passed  (out_res.passed),
  .out_outcome (out_res.outcome),
  .out_echo_id (out_res.echo_id)
);

// ----- verif/box_filter_track_decimator_tb.sv -----
`timescale 1ns / 1ps

typedef struct {
  logic signed [bftd_pkg::COORD_W-1:0] lx;
  logic signed [bftd_pkg::COORD_W-1:0] ty;
  logic signed [bftd_pkg::COORD_W-1:0] rx;
  logic signed [bftd_pkg::COORD_W-1:0] by;
  logic        [bftd_pkg::CONF_W-1:0]  conf;
  logic        [bftd_pkg::ID_W-1:0]    id;
} box_t;

typedef struct {
  logic                      passed;
  bftd_pkg::outcome_t        outcome;
  logic [bftd_pkg::ID_W-1:0] id;
} verdict_t;

class verdict_board;
  logic [bftd_pkg::PIX_W-1:0]  border;
  logic [bftd_pkg::PIX_W-1:0]  img_w;
  logic [bftd_pkg::PIX_W-1:0]  img_h;
  logic [bftd_pkg::PIX_W-1:0]  min_w;
  logic [bftd_pkg::PIX_W-1:0]  min_h;
  logic [bftd_pkg::CNT_W-1:0]  skip;
  logic [bftd_pkg::CONF_W-1:0] min_conf;

  logic [bftd_pkg::ID_W-1:0]  ids    [bftd_pkg::TRACK_LIMIT];
  logic [bftd_pkg::CNT_W-1:0] counts [bftd_pkg::TRACK_LIMIT];
  bit                         live   [bftd_pkg::TRACK_LIMIT];
  int                         oldest;
  int                         fill;

  verdict_t due[$];
  int       errors;

  function new();
    border   = bftd_pkg::RST_BORDER;
    img_w    = bftd_pkg::RST_IMG_W;
    img_h    = bftd_pkg::RST_IMG_H;
    min_w    = bftd_pkg::RST_MIN_W;
    min_h    = bftd_pkg::RST_MIN_H;
    skip     = bftd_pkg::RST_SKIP;
    min_conf = bftd_pkg::RST_MIN_CONF;
    foreach (live[i]) live[i] = 1'b0;
    oldest = 0;
    fill   = 0;
    errors = 0;
  endfunction

  function void set_reg(logic [bftd_pkg::REG_IDX_W-1:0] idx,
                        logic [bftd_pkg::CFG_DW-1:0] v);
    case (idx)
      bftd_pkg::REG_BORDER:   border   = v[bftd_pkg::PIX_W-1:0];
      bftd_pkg::REG_IMG_W:    img_w    = v[bftd_pkg::PIX_W-1:0];
      bftd_pkg::REG_IMG_H:    img_h    = v[bftd_pkg::PIX_W-1:0];
      bftd_pkg::REG_MIN_W:    min_w    = v[bftd_pkg::PIX_W-1:0];
      bftd_pkg::REG_MIN_H:    min_h    = v[bftd_pkg::PIX_W-1:0];
      bftd_pkg::REG_SKIP:     skip     = v[bftd_pkg::CNT_W-1:0];
      bftd_pkg::REG_MIN_CONF: min_conf = v[bftd_pkg::CONF_W-1:0];
      default: ;
    endcase
  endfunction

  function void take_box(box_t b);
    verdict_t   v;
    int         b16;
    int         wl;
    int         hl;
    int         hit;
    int         slot;
    bit         ok;
    logic [16:0] c;
    b16 = int'(border) * 16;
    wl  = (int'(img_w) - int'(border)) * 16;
    hl  = (int'(img_h) - int'(border)) * 16;
    ok  = (int'(b.lx) > b16) && (int'(b.ty) > b16) &&
          (int'(b.rx) < wl) && (int'(b.by) < hl) &&
          (int'(b.by) - int'(b.ty) > int'(min_h) * 16) &&
          (int'(b.rx) - int'(b.lx) > int'(min_w) * 16) &&
          (b.conf >= min_conf);
    v.id = b.id;
    if (!ok) begin
      v.passed  = 1'b0;
      v.outcome = bftd_pkg::OUT_REJECT;
    end else begin
      hit = -1;
      for (int i = 0; i < bftd_pkg::TRACK_LIMIT; i++) begin
        if (live[i] && ids[i] == b.id) begin
          hit = i;
          break;
        end
      end
      if (hit >= 0) begin
        c = {1'b0, counts[hit]} + 17'd1;
        if (c > 17'h0FFFF) c = 17'h0FFFF;
        if (c >= {1'b0, skip}) begin
          counts[hit] = '0;
          v.passed    = 1'b1;
          v.outcome   = bftd_pkg::OUT_PERIOD;
        end else begin
          counts[hit] = c[bftd_pkg::CNT_W-1:0];
          v.passed    = 1'b0;
          v.outcome   = bftd_pkg::OUT_SKIP;
        end
      end else begin
        if (fill >= bftd_pkg::TRACK_LIMIT) begin
          slot   = oldest;
          oldest = (oldest + 1) % bftd_pkg::TRACK_LIMIT;
        end else begin
          slot = (oldest + fill) % bftd_pkg::TRACK_LIMIT;
          fill++;
        end
        ids[slot]    = b.id;
        counts[slot] = '0;
        live[slot]   = 1'b1;
        v.passed     = 1'b1;
        v.outcome    = bftd_pkg::OUT_NEW;
      end
    end
    due.insert(due.size(), v);
  endfunction

  function void match_verdict(logic passed, logic [1:0] outcome,
                              logic [bftd_pkg::ID_W-1:0] id);
    verdict_t e;
    if (due.size() == 0) begin
      $error("unexpected result: passed %0d outcome %0d echo_id %h", passed, outcome, id);
      errors++;
      return;
    end
    e = due[0];
    due.delete(0);
    if (passed !== e.passed) begin
      $error("passed: expected %0d, got %0d", e.passed, passed);
      errors++;
    end
    if (outcome !== e.outcome) begin
      $error("outcome: expected %0d, got %0d", e.outcome, outcome);
      errors++;
    end
    if (id !== e.id) begin
      $error("echo_id: expected %h, got %h", e.id, id);
      errors++;
    end
  endfunction
endclass

module box_filter_track_decimator_tb;

  localparam logic [bftd_pkg::REG_IDX_W-1:0] REG_UNUSED = bftd_pkg::REG_IDX_W'(7);
  localparam int POOL_N = 40;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [bftd_pkg::CFG_AW-1:0] paddr;
  logic [bftd_pkg::CFG_DW-1:0] pwdata;
  logic [bftd_pkg::CFG_DW-1:0] prdata;
  logic pready;

  bftd_box_if box_ch ();
  bftd_res_if res_ch ();

  box_filter_track_decimator uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_box  (box_ch),
    .out_res (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  verdict_board              board;
  logic [bftd_pkg::ID_W-1:0] pool [POOL_N];
  bit                        steady;
  int                        stall_left;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(0, 2);
    if (r < 19) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // result side: random back-pressure unless steady, check every transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready)
        board.match_verdict(res_ch.passed, res_ch.outcome, res_ch.echo_id);
      if (steady) begin
        res_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  function automatic box_t mk(int lx, int ty, int rx, int by, int conf,
                              logic [bftd_pkg::ID_W-1:0] id);
    box_t b;
    b.lx   = bftd_pkg::COORD_W'(lx);
    b.ty   = bftd_pkg::COORD_W'(ty);
    b.rx   = bftd_pkg::COORD_W'(rx);
    b.by   = bftd_pkg::COORD_W'(by);
    b.conf = bftd_pkg::CONF_W'(conf);
    b.id   = id;
    return b;
  endfunction

  function automatic box_t noise_box(logic [bftd_pkg::ID_W-1:0] id);
    box_t b;
    b.lx   = bftd_pkg::COORD_W'($urandom());
    b.ty   = bftd_pkg::COORD_W'($urandom());
    b.rx   = bftd_pkg::COORD_W'($urandom());
    b.by   = bftd_pkg::COORD_W'($urandom());
    b.conf = bftd_pkg::CONF_W'($urandom_range(0, 32768));
    b.id   = id;
    return b;
  endfunction

  // box that fits the current setting, sometimes pushed onto one threshold; noise if none fits
  function automatic box_t shaped_box(logic [bftd_pkg::ID_W-1:0] id);
    box_t b;
    int b16;
    int wl;
    int hl;
    int mw;
    int mh;
    int xroom;
    int yroom;
    int xextra;
    int yextra;
    int lx;
    int ty;
    b   = noise_box(id);
    b16 = int'(board.border) * 16;
    wl  = (int'(board.img_w) - int'(board.border)) * 16;
    hl  = (int'(board.img_h) - int'(board.border)) * 16;
    mw  = int'(board.min_w) * 16 + 1;
    mh  = int'(board.min_h) * 16 + 1;
    xroom = wl - 1 - (b16 + 1) - mw;
    yroom = hl - 1 - (b16 + 1) - mh;
    if (xroom < 0 || yroom < 0) return b;
    xextra = $urandom_range(0, xroom);
    yextra = $urandom_range(0, yroom);
    lx = b16 + 1 + $urandom_range(0, xroom - xextra);
    ty = b16 + 1 + $urandom_range(0, yroom - yextra);
    b.lx   = bftd_pkg::COORD_W'(lx);
    b.rx   = bftd_pkg::COORD_W'(lx + mw + xextra);
    b.ty   = bftd_pkg::COORD_W'(ty);
    b.by   = bftd_pkg::COORD_W'(ty + mh + yextra);
    b.conf = bftd_pkg::CONF_W'($urandom_range(board.min_conf, 32768));
    case ($urandom_range(0, 11))
      0: b.lx = bftd_pkg::COORD_W'(b16);
      1: b.ty = bftd_pkg::COORD_W'(b16);
      2: b.rx = bftd_pkg::COORD_W'(wl);
      3: b.by = bftd_pkg::COORD_W'(hl);
      4: b.rx = bftd_pkg::COORD_W'(int'(b.lx) + mw - 1);
      5: b.by = bftd_pkg::COORD_W'(int'(b.ty) + mh - 1);
      6: b.conf = board.min_conf;
      7: if (board.min_conf != 0) b.conf = board.min_conf - 1'b1;
      default: ;
    endcase
    return b;
  endfunction

  function automatic logic [bftd_pkg::ID_W-1:0] pool_id();
    return pool[$urandom_range(0, $urandom_range(3, POOL_N - 1))];
  endfunction

  function automatic logic [bftd_pkg::CFG_DW-1:0] with_junk(int w, int unsigned v);
    return ($urandom() << w) | v;
  endfunction

  task automatic send_box(input box_t b);
    int gap;
    gap = steady ? 0 : (($urandom_range(0, 2) == 0) ? pick_gap() : 0);
    if (gap > 0) begin
      box_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    box_ch.valid      <= 1'b1;
    box_ch.left_x     <= b.lx;
    box_ch.top_y      <= b.ty;
    box_ch.right_x    <= b.rx;
    box_ch.bottom_y   <= b.by;
    box_ch.confidence <= b.conf;
    box_ch.track_id   <= b.id;
    do @(posedge clk); while (!box_ch.ready);
    board.take_box(b);
  endtask

  task automatic drain();
    box_ch.valid <= 1'b0;
    while (board.due.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [bftd_pkg::REG_IDX_W-1:0] idx,
                           input logic [bftd_pkg::CFG_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bftd_pkg::CFG_AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    board.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic rand_config();
    cfg_write(bftd_pkg::REG_BORDER, with_junk(bftd_pkg::PIX_W,
      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 40)));
    cfg_write(bftd_pkg::REG_IMG_W, with_junk(bftd_pkg::PIX_W, $urandom_range(100, 2047)));
    cfg_write(bftd_pkg::REG_IMG_H, with_junk(bftd_pkg::PIX_W, $urandom_range(100, 2047)));
    cfg_write(bftd_pkg::REG_MIN_W, with_junk(bftd_pkg::PIX_W,
      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 150)));
    cfg_write(bftd_pkg::REG_MIN_H, with_junk(bftd_pkg::PIX_W,
      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 150)));
    cfg_write(bftd_pkg::REG_SKIP, with_junk(bftd_pkg::CNT_W,
      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 6)));
    cfg_write(bftd_pkg::REG_MIN_CONF, with_junk(bftd_pkg::CONF_W, $urandom_range(0, 32768)));
  endtask

  initial begin
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    box_ch.valid      = 1'b0;
    box_ch.left_x     = '0;
    box_ch.top_y      = '0;
    box_ch.right_x    = '0;
    box_ch.bottom_y   = '0;
    box_ch.confidence = '0;
    box_ch.track_id   = '0;
    res_ch.ready      = 1'b0;
    steady            = 1'b0;
    board             = new();
    pool[0] = 32'h0000_0000;
    pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_N; i++) pool[i] = $urandom();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: b16 320, right limit 30400, bottom limit 16960, min size 1600
    send_box(mk(321, 321, 2000, 2000, 26214, 32'h0000_0000));
    send_box(mk(320, 400, 2500, 2500, 30000, 32'h0000_0B0B));
    send_box(mk(400, 320, 2500, 2500, 30000, 32'h0000_0B0B));
    send_box(mk(400, 400, 30400, 2500, 30000, 32'h0000_0B0B));
    send_box(mk(321, 321, 30399, 16959, 32768, 32'hFFFF_FFFF));
    send_box(mk(400, 400, 2500, 16960, 30000, 32'h0000_0B0B));
    send_box(mk(400, 400, 2000, 2500, 30000, 32'h0000_0B0B));
    send_box(mk(400, 400, 2500, 2000, 30000, 32'h0000_0B0B));
    send_box(mk(321, 321, 2000, 2000, 26213, 32'h0000_0000));  // rejected, table untouched
    send_box(mk(-32768, -32768, 32767, 32767, 32768, 32'h0000_0B0B));
    send_box(mk(32767, 32767, -32768, -32768, 0, 32'h0000_0B0B));
    repeat (4) send_box(mk(1000, 1000, 5000, 5000, 30000, 32'h1234_5678));
    repeat (5) send_box(mk(500, 600, 3000, 4000, 32768, 32'hFFFF_FFFF));
    send_box(mk(321, 321, 2000, 2000, 26214, 32'h0000_0000));
    drain();

    // out-of-range register, then lowered period catches counts already past it
    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_write(bftd_pkg::REG_SKIP, 32'd2);
    send_box(mk(1000, 1000, 5000, 5000, 30000, 32'h1234_5678));
    send_box(mk(321, 321, 2000, 2000, 26214, 32'h0000_0000));
    drain();

    cfg_write(bftd_pkg::REG_SKIP, 32'd0);
    send_box(mk(1000, 1000, 5000, 5000, 30000, 32'h1234_5678));
    drain();

    // border beyond the image width
    cfg_write(bftd_pkg::REG_BORDER, 32'd2047);
    send_box(mk(400, 400, 2500, 2500, 30000, 32'h0000_0B0B));
    drain();

    cfg_write(bftd_pkg::REG_BORDER, 32'd0);
    cfg_write(bftd_pkg::REG_IMG_W, 32'd2047);
    cfg_write(bftd_pkg::REG_IMG_H, 32'd2047);
    cfg_write(bftd_pkg::REG_MIN_W, 32'd0);
    cfg_write(bftd_pkg::REG_MIN_H, 32'd0);
    cfg_write(bftd_pkg::REG_SKIP, 32'd65535);
    cfg_write(bftd_pkg::REG_MIN_CONF, 32'd32768);
    send_box(mk(1, 1, 32751, 32751, 32768, 32'h0000_C0DE));
    send_box(mk(0, 1, 32751, 32751, 32768, 32'h0000_C0DE));
    send_box(mk(1, 1, 2, 2, 32767, 32'h0000_C0DE));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      steady = (ph == 3);
      rand_config();
      for (int k = 0; k < 60; k++) begin
        if ($urandom_range(0, 3) == 0)
          send_box(noise_box(($urandom_range(0, 1) == 0) ? pool_id() : $urandom()));
        else
          send_box(shaped_box(pool_id()));
      end
      drain();
    end
    steady = 1'b0;

    repeat (1100) @(posedge clk);
    if (board.errors == 0 && board.due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
